[sv/twn_pkg.sv]
// Shared types and constants of the text whitespace normalizer.
package twn_pkg;

	// Line break and the single space that stands for an inner whitespace run
	localparam logic [7:0] NlChar = 8'd10;
	localparam logic [7:0] SpChar = 8'd32;

	// Most results one input byte can cause, and the width of a result count
	localparam int MaxResults = 3;
	localparam int CntW = $clog2(MaxResults + 1);

	// Default depth of the bundle queue between front and back
	localparam int QueueDepthDef = 4;

	// One input request
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	// One result request
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       text_done;
	} result_t;

	// All results of one input byte, slot 0 first
	typedef struct packed {
		logic [CntW-1:0]                 count;
		result_t [MaxResults-1:0]        res;
	} bundle_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[sv/text_whitespace_normalizer.sv]
// Top level of the text whitespace normalizer.
// Takes one text byte per cycle and gives normalized bytes one per cycle on the result side.
// Each byte causes zero to three results; the front end classifies the byte and queues its
// results as one bundle, and the back end sends them out one per cycle through an output
// register. A byte is taken every cycle while the bundle queue (QueueDepth bundles) has room;
// the result side sets the sustained rate at one result per cycle, so bursts of spaces and
// line breaks that add results slow input only once the queue fills. An accepted byte's bundle
// is queued, and its results pass through the output register. The last byte of a text gives
// a result with text_done set, a bare marker with byte_valid low when it causes no character.
module text_whitespace_normalizer #(
	parameter int QueueDepth = twn_pkg::QueueDepthDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  twn_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output twn_pkg::result_t result
);

	logic               push, pop;
	twn_pkg::bundle_t   push_bundle, head;
	twn_pkg::q_status_t q_status;

	twn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_bundle(push_bundle)
	);

	twn_queue #(
		.QueueDepth(QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bundle(push_bundle),
		.pop        (pop),
		.head       (head),
		.q_status   (q_status)
	);

	twn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

[sv/twn_front.sv]
// Front end: accepts bytes, tracks line state and builds the result bundle of each byte.
module twn_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  twn_pkg::item_t     item,
	input  twn_pkg::q_status_t q_status,
	output logic               push,
	output twn_pkg::bundle_t   push_bundle
);

	logic line_has_content_q, space_pending_q, blank_line_pending_q, output_started_q;
	logic lhc_n, sp_n, blp_n, os_n;
	logic is_nl, is_ws, accept;
	logic [twn_pkg::CntW-1:0] n;
	twn_pkg::bundle_t bundle;

	function automatic twn_pkg::result_t mk_char(input logic [7:0] c);
		twn_pkg::result_t r;
		r.out_byte   = c;
		r.byte_valid = 1'b1;
		r.text_done  = 1'b0;
		return r;
	endfunction

	// Classify the byte
	assign is_nl = (item.text_byte == twn_pkg::NlChar);
	assign is_ws = (item.text_byte == twn_pkg::SpChar) || (item.text_byte == 8'd9) ||
		(item.text_byte == 8'd11) || (item.text_byte == 8'd12) || (item.text_byte == 8'd13);

	// Take a request whenever the queue has room for its bundle
	assign item_ready = !q_status.full;
	assign accept     = item_valid && item_ready;

	// Build the bundle and the next line state
	always_comb begin
		bundle = '0;
		n      = '0;
		lhc_n  = line_has_content_q;
		sp_n   = space_pending_q;
		blp_n  = blank_line_pending_q;
		os_n   = output_started_q;
		if (is_nl) begin
			if (line_has_content_q) begin
				bundle.res[n] = mk_char(twn_pkg::NlChar);
				n = n + 1'b1;
			end else begin
				blp_n = 1'b1;
			end
			lhc_n = 1'b0;
			sp_n  = 1'b0;
		end else if (is_ws) begin
			if (line_has_content_q) begin
				sp_n = 1'b1;
			end
		end else begin
			if (!line_has_content_q) begin
				// Emit one empty line for any blank lines between content lines
				if (blank_line_pending_q && output_started_q) begin
					bundle.res[n] = mk_char(twn_pkg::NlChar);
					n = n + 1'b1;
				end
				blp_n = 1'b0;
				lhc_n = 1'b1;
			end else if (space_pending_q) begin
				bundle.res[n] = mk_char(twn_pkg::SpChar);
				n = n + 1'b1;
			end
			sp_n = 1'b0;
			bundle.res[n] = mk_char(item.text_byte);
			n = n + 1'b1;
			os_n = 1'b1;
		end
		if (item.end_of_text) begin
			// Close the open line, mark the last result, return to reset state
			if (lhc_n) begin
				bundle.res[n] = mk_char(twn_pkg::NlChar);
				n = n + 1'b1;
			end
			if (n == '0) begin
				bundle.res[0] = '0;
				n = twn_pkg::CntW'(1);
			end
			bundle.res[n - 1'b1].text_done = 1'b1;
			lhc_n = 1'b0;
			sp_n  = 1'b0;
			blp_n = 1'b0;
			os_n  = 1'b0;
		end
		bundle.count = n;
	end

	// Push only bundles that hold results
	assign push        = accept && (n != '0);
	assign push_bundle = bundle;

	// Hold line state, advance on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_has_content_q   <= 1'b0;
			space_pending_q      <= 1'b0;
			blank_line_pending_q <= 1'b0;
			output_started_q     <= 1'b0;
		end else if (accept) begin
			line_has_content_q   <= lhc_n;
			space_pending_q      <= sp_n;
			blank_line_pending_q <= blp_n;
			output_started_q     <= os_n;
		end
	end

endmodule

[sv/twn_queue.sv]
// Bundle queue between the front end and the back end.
module twn_queue #(
	parameter int QueueDepth = twn_pkg::QueueDepthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  twn_pkg::bundle_t   push_bundle,
	input  logic               pop,
	output twn_pkg::bundle_t   head,
	output twn_pkg::q_status_t q_status
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntQW = $clog2(QueueDepth + 1);

	twn_pkg::bundle_t entries_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntQW-1:0] count_q;

	assign q_status.full  = (count_q == CntQW'(QueueDepth));
	assign q_status.empty = (count_q == '0);
	assign head           = entries_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	// Store a pushed bundle
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/twn_back.sv]
// Back end: unpacks queued bundles into single result requests behind an output register.
module twn_back (
	input  logic               clk,
	input  logic               arst_n,
	input  twn_pkg::bundle_t   head,
	input  twn_pkg::q_status_t q_status,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output twn_pkg::result_t   result
);

	logic [twn_pkg::CntW-1:0] slot_q;
	logic                     out_valid_q;
	twn_pkg::result_t         out_q;
	logic                     load, last_slot;

	// Load the next slot when the output register is free or being drained
	assign load      = !q_status.empty && (!out_valid_q || result_ready);
	assign last_slot = (slot_q == head.count - 1'b1);
	assign pop       = load && last_slot;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Hold the output payload until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= head.res[slot_q];
		end
	end

	// Step through the slots of the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				slot_q      <= last_slot ? '0 : slot_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/twn_checker.sv]
// Port-level checker of the text whitespace normalizer and its bind.
module twn_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input twn_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_ready,
	input twn_pkg::result_t result
);

	logic       out_acc;
	logic       text_start_q;
	logic [7:0] prev_byte_q;
	logic       prev_valid_q;

	assign out_acc = result_valid && result_ready;

	// Track the previous delivered character and whether a text has just begun
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_start_q <= 1'b1;
			prev_valid_q <= 1'b0;
			prev_byte_q  <= '0;
		end else if (out_acc) begin
			text_start_q <= result.text_done;
			prev_valid_q <= result.byte_valid && !result.text_done;
			prev_byte_q  <= result.out_byte;
		end
	end

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A bare marker only closes a text
	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.text_done && result.out_byte == 8'd0)
		else $error("bare result without end mark");

	// A text never opens with a space or a line break
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && text_start_q && result.byte_valid |->
			result.out_byte != twn_pkg::NlChar && result.out_byte != twn_pkg::SpChar)
		else $error("text opens with whitespace");

	// A space is always followed by content
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q && prev_byte_q == twn_pkg::SpChar |->
			result.byte_valid && result.out_byte != twn_pkg::NlChar &&
			result.out_byte != twn_pkg::SpChar)
		else $error("space not followed by content");

	// Unused by the checks but part of the port view
	logic unused_in;
	assign unused_in = item_valid & item_ready & (^item);

endmodule

bind text_whitespace_normalizer twn_checker u_twn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

[test/twn_text_pkg.sv]
// Character classes shared by the normalizer checker and its stimulus.
`timescale 1ns / 100ps
package twn_text_pkg;

	import twn_pkg::*;

	// Whitespace codes besides the plain space
	localparam logic [7:0] TabChar = 8'd9;
	localparam logic [7:0] VtChar  = 8'd11;
	localparam logic [7:0] FfChar  = 8'd12;
	localparam logic [7:0] CrChar  = 8'd13;

	localparam logic [7:0] BlankChars [5] = '{SpChar, TabChar, VtChar, FfChar, CrChar};

	// Whitespace that folds into one space; the line break is not among them
	function automatic logic is_blank(input logic [7:0] c);
		return c == SpChar || c == TabChar || c == VtChar || c == FfChar || c == CrChar;
	endfunction

endpackage

[test/twn_checker.sv]
// Checker of the whitespace normalizer: predicts results per request and compares them.
`timescale 1ns / 100ps
module twn_tb_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  twn_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_ready,
	input  twn_pkg::result_t result,
	output int unsigned      mismatch_count,
	output int unsigned      pending_results
);

	import twn_pkg::*;
	import twn_text_pkg::*;

	// Predicted line state
	logic line_open;
	logic gap_seen;
	logic blank_seen;
	logic text_started;

	result_t expected_results [$];

	function automatic result_t char_result(input logic [7:0] c);
		return '{out_byte: c, byte_valid: 1'b1, text_done: 1'b0};
	endfunction

	// Fold one text byte into the line state and queue the bytes it yields
	task automatic normalize_byte(input item_t req);
		int unsigned n;
		result_t tail;
		n = 0;
		if (req.text_byte == NlChar) begin
			if (line_open) begin
				expected_results.push_back(char_result(NlChar));
				n++;
			end else
				blank_seen = 1'b1;
			line_open = 1'b0;
			gap_seen = 1'b0;
		end else if (is_blank(req.text_byte)) begin
			if (line_open)
				gap_seen = 1'b1;
		end else begin
			if (!line_open) begin
				// one empty line stands for any run of blank lines between content
				if (blank_seen && text_started) begin
					expected_results.push_back(char_result(NlChar));
					n++;
				end
				blank_seen = 1'b0;
				line_open = 1'b1;
			end else if (gap_seen) begin
				expected_results.push_back(char_result(SpChar));
				n++;
			end
			gap_seen = 1'b0;
			expected_results.push_back(char_result(req.text_byte));
			n++;
			text_started = 1'b1;
		end

		// Close the text: final newline, bare marker if nothing came, then clear state
		if (req.end_of_text) begin
			if (line_open) begin
				expected_results.push_back(char_result(NlChar));
				n++;
			end
			if (n == 0)
				expected_results.push_back('{out_byte: 8'd0, byte_valid: 1'b0, text_done: 1'b0});
			tail = expected_results.pop_back();
			tail.text_done = 1'b1;
			expected_results.push_back(tail);
			line_open = 1'b0;
			gap_seen = 1'b0;
			blank_seen = 1'b0;
			text_started = 1'b0;
		end
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			$error("unexpected result: out_byte %0d byte_valid %0b text_done %0b",
				got.out_byte, got.byte_valid, got.text_done);
			mismatch_count++;
			return;
		end
		want = expected_results.pop_front();
		if (got.out_byte !== want.out_byte) begin
			$error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
			mismatch_count++;
		end
		if (got.byte_valid !== want.byte_valid) begin
			$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
			mismatch_count++;
		end
		if (got.text_done !== want.text_done) begin
			$error("text_done: expected %0b, got %0b", want.text_done, got.text_done);
			mismatch_count++;
		end
	endtask

	// Sample both channels on the falling edge ahead of the rising edge that completes the request
	always @(negedge clk or negedge arst_n) begin : track
		if (!arst_n) begin
			line_open = 1'b0;
			gap_seen = 1'b0;
			blank_seen = 1'b0;
			text_started = 1'b0;
			mismatch_count = 0;
			expected_results.delete();
		end else begin
			if (result_valid && result_ready)
				check_result(result);
			if (item_valid && item_ready)
				normalize_byte(item);
		end
		pending_results = expected_results.size();
	end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the text whitespace normalizer.
`timescale 1ns / 100ps
module testbench;

	import twn_pkg::*;
	import twn_text_pkg::*;

	localparam int unsigned HoldCycles = 300;
	localparam int unsigned QuietLimit = 2000;
	localparam int unsigned TotalBytes = 330;

	// Short texts: blank lines ahead of content, inner runs, trailing blanks,
	// high bytes, end on content, on whitespace, on a line break and alone
	localparam logic [8:0] DirectedText [23] = '{
		{NlChar, 1'b0}, {TabChar, 1'b0}, {8'h41, 1'b0}, {SpChar, 1'b0}, {VtChar, 1'b0},
		{8'h62, 1'b0}, {CrChar, 1'b0}, {FfChar, 1'b0}, {NlChar, 1'b0}, {NlChar, 1'b0},
		{NlChar, 1'b0}, {8'hFF, 1'b0}, {SpChar, 1'b0}, {8'h80, 1'b0}, {NlChar, 1'b0},
		{8'h00, 1'b1},
		{SpChar, 1'b1},
		{8'h78, 1'b0}, {NlChar, 1'b1},
		{NlChar, 1'b0}, {NlChar, 1'b1},
		{8'h71, 1'b0}, {TabChar, 1'b1}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	int unsigned mismatch_count;
	int unsigned pending_results;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	bit          sender_idle = 1'b0;
	bit          receiver_idle = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	text_whitespace_normalizer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	twn_tb_checker u_tb_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// Drive result_ready: long hold on request, else random stall bursts while receiver_idle is set
	always @(posedge clk) begin : result_side
		if (hold_requests != holds_done) begin
			holds_done++;
			hold_left = HoldCycles - 1;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			result_ready <= 1'b0;
		end else
			result_ready <= 1'b1;
	end

	// End the run when no request moves on either side for too long
	always @(negedge clk) begin : watchdog
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else if (quiet_cycles == QuietLimit) begin
			$display("end of test: mismatches");
			$finish;
		end else
			quiet_cycles++;
	end

	// Offer one byte, at times with a random gap ahead of it while sender_idle is set, and hold it until accepted
	task automatic send_byte(input logic [7:0] c, input logic last);
		if (sender_idle && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item <= '{text_byte: c, end_of_text: last};
		item_valid <= 1'b1;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		bytes_sent++;
	endtask

	// Pick a byte of plausible text: line breaks, whitespace and content
	function automatic logic [7:0] text_char();
		logic [7:0] c;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 18)
			return NlChar;
		if (r < 45)
			return BlankChars[$urandom_range(0, 4)];
		do c = 8'($urandom_range(0, 255)); while (c == NlChar || is_blank(c));
		return c;
	endfunction

	// Send whole texts until the byte count reaches the target; some are pure noise
	task automatic send_texts(input int unsigned target);
		int unsigned len;
		bit noisy;
		while (bytes_sent < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
			noisy = ($urandom_range(0, 4) == 0);
			for (int unsigned k = 0; k < len; k++)
				send_byte(noisy ? 8'($urandom_range(0, 255)) : text_char(), k == len - 1);
		end
	endtask

	// Drop valid and wait until every predicted result has come
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		foreach (DirectedText[i])
			send_byte(DirectedText[i][8:1], DirectedText[i][0]);

		send_texts(140);

		// pause the sender until everything is out
		wait_drained();

		// hold the receiver off while the sender keeps offering
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		hold_requests++;
		send_texts(bytes_sent + 40);

		// stretch with no idling, then random idling again
		send_texts(210);
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
		send_texts(280);

		// last part runs without idling
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		send_texts(TotalBytes);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
